[hdl/atb_pkg.sv]
// ----------------------------------------------------------------------------
// atb_pkg: shared types and constants for the alias table builder
// Holds the build sequencer states, the fixed field widths and the message
// that each cell hands to its neighbor in the chain.
// ----------------------------------------------------------------------------
package atb_pkg;

  localparam int unsigned ProbW  = 31;
  localparam int unsigned FracW  = 32;
  localparam int unsigned CountW = 7;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_SCAN,
    ST_APPLY,
    ST_EMIT
  } state_e;

  // Running candidates of one scan, handed from cell to cell.
  typedef struct packed {
    logic               found;
    logic signed [33:0] rmax;
    logic signed [33:0] rmin;
    logic [5:0]         jmax;
    logic [5:0]         jmin;
  } scan_t;

  // Update of one round, broadcast to every cell.
  typedef struct packed {
    logic               apply;
    logic [5:0]         jmax;
    logic [5:0]         jmin;
    logic signed [31:0] cons_max;
    logic signed [31:0] frac_min;
  } upd_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) r = 32'sh7fffffff;
    else if (v < -48'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[hdl/atb_cell.sv]
// ----------------------------------------------------------------------------
// atb_cell: one table row of the alias table builder
// Keeps probability, consumed amount, alias and assigned flag for its row and
// folds its residual into the scan message on its way along the chain.
// ----------------------------------------------------------------------------
module atb_cell #(
  parameter logic [5:0] Idx = 6'd0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic [30:0]         prob_i,
  input  logic                clear_i,
  input  logic                scan_i,
  input  logic                in_range_i,
  input  atb_pkg::scan_t      scan_in_i,
  output atb_pkg::scan_t      scan_out_o,
  input  atb_pkg::upd_t       upd_i,
  output logic [5:0]          alias_o,
  output logic signed [31:0]  cons_o
);

  logic [30:0]        prob_q;
  logic signed [31:0] cons_q;
  logic [5:0]         alias_q;
  logic               asg_q;
  logic signed [33:0] r;
  atb_pkg::scan_t     scan_d;
  atb_pkg::scan_t     scan_q;

  assign r = $signed({3'b000, prob_q}) - 34'(cons_q);

  always_comb begin
    scan_d = scan_in_i;
    if (scan_i && in_range_i && !asg_q) begin
      if (!scan_in_i.found || scan_in_i.rmax <= r) begin
        scan_d.rmax = r;
        scan_d.jmax = Idx;
      end
      if (!scan_in_i.found || scan_in_i.rmin >= r) begin
        scan_d.rmin = r;
        scan_d.jmin = Idx;
      end
      scan_d.found = 1'b1;
    end
  end

  // The scan message moves one cell along the chain per cycle.
  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
  end

  assign scan_out_o = scan_q;
  assign alias_o    = alias_q;
  assign cons_o     = cons_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asg_q  <= 1'b0;
      cons_q <= '0;
    end else if (clear_i) begin
      asg_q  <= 1'b0;
      cons_q <= '0;
    end else if (upd_i.apply) begin
      if (upd_i.jmin == Idx) begin
        asg_q  <= 1'b1;
        cons_q <= upd_i.frac_min;
      end else if (upd_i.jmax == Idx) begin
        cons_q <= upd_i.cons_max;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) prob_q <= prob_i;
    if (upd_i.apply && upd_i.jmin == Idx) alias_q <= upd_i.jmax;
  end

endmodule

[hdl/alias_table_builder_top.sv]
// ----------------------------------------------------------------------------
// alias_table_builder_top: Walker alias table builder
// Loads probabilities into a chain of row cells, builds the table, emits rows.
// ----------------------------------------------------------------------------
// Usage: write entry_count (index 0) and reciprocal_count (index 1) while
// idle. Send entry_count probability beats on the input channel, in index
// order. The beat that completes the set starts a build: a clear step,
// then n rounds. In each round the scan message walks the cell chain one
// cell per cycle and an update step follows. After the last round, n rows
// leave on the output channel, one per cycle while out_stall_i is low,
// last_row_o marking the final one. Load beats are taken one per cycle in
// the load state; the block takes no input during build and emit.
// Reset clears the load counter and state machine and restores the register
// defaults (64 entries, reciprocal 2^24). A stall on the output holds the
// current row in the output register until it is taken.
// ----------------------------------------------------------------------------
module alias_table_builder_top #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [30:0]        probability_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         entry_index_o,
  output logic [5:0]         alias_index_o,
  output logic signed [31:0] alias_fraction_o,
  output logic               last_row_o
);

  localparam int unsigned IW = $clog2(MAX_ENTRIES);

  logic [6:0]          count_q;
  logic [30:0]         recip_q;
  logic [6:0]          n;
  logic [6:0]          lc_q, lc_d, lc_eff;
  logic [6:0]          rnd_q, rnd_d;
  logic [6:0]          sc_q, sc_d;
  atb_pkg::state_e     st_q, st_d;
  atb_pkg::scan_t      chain [MAX_ENTRIES+1];
  atb_pkg::scan_t      scan_q;
  atb_pkg::upd_t       upd;
  logic [5:0]          alias_w [MAX_ENTRIES];
  logic signed [31:0]  cons_w [MAX_ENTRIES];
  logic                in_acc, out_acc;
  logic signed [33:0]  amount;
  logic signed [47:0]  sum_max, prod_min;
  logic signed [31:0]  cons_max_q;

  always_comb begin
    if (count_q == 7'd0) n = 7'd1;
    else if (count_q > 7'(MAX_ENTRIES)) n = 7'(MAX_ENTRIES);
    else n = count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 7'd64;
      recip_q <= 31'd16777216;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == 1'b0) count_q <= cfg_data_i[6:0];
      else recip_q <= cfg_data_i;
    end
  end

  assign in_stall_o = (st_q != atb_pkg::ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign lc_eff     = (lc_q >= n) ? 7'd0 : lc_q;
  assign out_acc    = out_valid_o && !out_stall_i;

  assign chain[0] = '0;
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    atb_cell #(.Idx(6'(g))) u_cell (
      .clk_i, .rst_ni,
      .load_i     (in_acc && lc_eff[IW-1:0] == IW'(g)),
      .prob_i     (probability_i),
      .clear_i    (st_q == atb_pkg::ST_CLEAR),
      .scan_i     (st_q == atb_pkg::ST_SCAN),
      .in_range_i (7'(g) < n),
      .scan_in_i  (chain[g]),
      .scan_out_o (chain[g+1]),
      .upd_i      (upd),
      .alias_o    (alias_w[g]),
      .cons_o     (cons_w[g])
    );
  end

  // Charges for the round, from the registered scan result.
  assign amount   = $signed({3'b000, recip_q}) - scan_q.rmin;
  assign sum_max  = 48'(cons_max_q) + 48'(amount);
  assign prod_min = 48'(amount) * $signed({41'd0, n});

  always_comb begin
    upd.apply    = (st_q == atb_pkg::ST_APPLY);
    upd.jmax     = scan_q.jmax;
    upd.jmin     = scan_q.jmin;
    upd.cons_max = atb_pkg::sat32(sum_max);
    upd.frac_min = atb_pkg::sat32(prod_min);
  end

  always_comb begin
    st_d  = st_q;
    lc_d  = lc_q;
    rnd_d = rnd_q;
    sc_d  = sc_q;
    case (st_q)
      atb_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (lc_eff + 7'd1 >= n) begin
            lc_d = 7'd0;
            st_d = atb_pkg::ST_CLEAR;
          end else begin
            lc_d = lc_eff + 7'd1;
          end
        end
      end
      atb_pkg::ST_CLEAR: begin
        rnd_d = 7'd0;
        sc_d  = 7'd0;
        st_d  = atb_pkg::ST_SCAN;
      end
      atb_pkg::ST_SCAN: begin
        // The result is taken from chain[n], the output of the last used cell, when sc_q equals n.
        sc_d = sc_q + 7'd1;
        if (sc_q == n) begin
          sc_d = 7'd0;
          st_d = atb_pkg::ST_APPLY;
        end
      end
      atb_pkg::ST_APPLY: begin
        rnd_d = rnd_q + 7'd1;
        if (rnd_q + 7'd1 >= n) begin
          rnd_d = 7'd0;
          st_d  = atb_pkg::ST_EMIT;
        end else begin
          st_d = atb_pkg::ST_SCAN;
        end
      end
      atb_pkg::ST_EMIT: begin
        if (out_acc) begin
          rnd_d = rnd_q + 7'd1;
          if (last_row_o) st_d = atb_pkg::ST_LOAD;
        end
      end
      default: st_d = atb_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= atb_pkg::ST_LOAD;
      lc_q  <= '0;
      rnd_q <= '0;
      sc_q  <= '0;
    end else begin
      st_q  <= st_d;
      lc_q  <= lc_d;
      rnd_q <= rnd_d;
      sc_q  <= sc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == atb_pkg::ST_SCAN && sc_q == n) begin
      scan_q     <= chain[n];
      cons_max_q <= cons_w[chain[n].jmax[IW-1:0]];
    end
  end

  // Output row register; loaded when empty or when its row is taken.
  logic        ov_q;
  logic [6:0]  orow_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      orow_q <= '0;
    end else if (st_q == atb_pkg::ST_EMIT && (!ov_q || out_acc)) begin
      if (!(out_acc && last_row_o) && (ov_q ? orow_q + 7'd1 : 7'd0) < n) begin
        ov_q   <= 1'b1;
        orow_q <= ov_q ? orow_q + 7'd1 : 7'd0;
      end else begin
        ov_q <= 1'b0;
      end
    end else if (out_acc) begin
      ov_q <= 1'b0;
    end
  end

  assign out_valid_o      = ov_q;
  assign entry_index_o    = orow_q[5:0];
  assign alias_index_o    = alias_w[orow_q[IW-1:0]];
  assign alias_fraction_o = cons_w[orow_q[IW-1:0]];
  assign last_row_o       = (orow_q + 7'd1 == n);

endmodule

[hdl/atb_checker.sv]
// ----------------------------------------------------------------------------
// atb_checker: port-level checks for the alias table builder
// Watches the output handshake, the row sequence and the input stall.
// ----------------------------------------------------------------------------
module atb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [5:0]  entry_index_o,
  input logic        last_row_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(entry_index_o))
    else $error("stalled output beat changed");

  a_no_load_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while rows are emitted");

  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_row_o |=>
      out_valid_o && entry_index_o == $past(entry_index_o) + 6'd1)
    else $error("row index skipped");

  a_first_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> entry_index_o == 6'd0)
    else $error("table did not start at row zero");

endmodule

bind alias_table_builder_top atb_checker u_atb_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i,
  .entry_index_o, .last_row_o
);
